// ===== design/ds_pkg.sv =====
// ----------------------------------------------------------------------------
// ds_pkg - shared types and constants for the dedup stack
// request kinds, result status codes and the sequencer state type
// ----------------------------------------------------------------------------
package ds_pkg;

    localparam int unsigned DATA_W = 32;

    // request kind codes
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // data returned by a pop of an empty stack
    localparam logic signed [DATA_W-1:0] DATA_EMPTY = 32'shFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_PUSHED = 3'd0,
        ST_FULL   = 3'd1,
        ST_DUP    = 3'd2,
        ST_POPPED = 3'd3,
        ST_EMPTY  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_POP_RD,
        S_DONE
    } t_state;

    // finished result offered by the sequencer to the output register
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] data;
        t_status                  status;
    } t_res;

endpackage

// ===== design/ds_if.sv =====
// ----------------------------------------------------------------------------
// ds_if - request and response channels of the dedup stack
// valid / ready handshake, a transfer happens when both are high
// ----------------------------------------------------------------------------
interface ds_req_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [31:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface ds_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] data;
    logic [2:0]         status;

    modport source (output valid, output data, output status, input ready);
    modport sink   (input valid, input data, input status, output ready);
endinterface

// ===== design/ds_ram.sv =====
// ----------------------------------------------------------------------------
// ds_ram - entry store of the dedup stack
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module ds_ram #(
    parameter int unsigned DEPTH = 512
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [$clog2(DEPTH)-1:0]            i_waddr,
    input  logic signed [ds_pkg::DATA_W-1:0]    i_wdata,
    input  logic [$clog2(DEPTH)-1:0]            i_raddr,
    output logic signed [ds_pkg::DATA_W-1:0]    o_rdata
);
    import ds_pkg::*;

    logic signed [DATA_W-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== design/ds_ctrl.sv =====
// ----------------------------------------------------------------------------
// ds_ctrl - sequencer of the dedup stack
// walks the stored entries through one compare unit for a push, reads the
// top entry for a pop, and holds the finished result until it is taken
// ----------------------------------------------------------------------------
module ds_ctrl #(
    parameter int unsigned DEPTH = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_req_valid,
    output logic                                o_req_ready,
    input  logic                                i_kind,
    input  logic signed [ds_pkg::DATA_W-1:0]    i_value,
    output logic                                o_mem_we,
    output logic [$clog2(DEPTH)-1:0]            o_mem_waddr,
    output logic signed [ds_pkg::DATA_W-1:0]    o_mem_wdata,
    output logic [$clog2(DEPTH)-1:0]            o_mem_raddr,
    input  logic signed [ds_pkg::DATA_W-1:0]    i_mem_rdata,
    output ds_pkg::t_res                        o_res,
    input  logic                                i_res_take
);
    import ds_pkg::*;

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned AW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] COUNT_FULL = AW'(DEPTH);

    t_state                   r_state, n_state;
    logic [AW-1:0]            r_count, n_count;
    logic [AW-1:0]            r_idx,   n_idx;
    logic signed [DATA_W-1:0] r_val,   n_val;
    logic signed [DATA_W-1:0] r_res_data, n_res_data;
    t_status                  r_res_status, n_res_status;
    logic [AW-1:0]            w_count_dec;
    logic [AW-1:0]            w_count_inc;

    assign w_count_dec = r_count - AW'(1);
    assign w_count_inc = r_count + AW'(1);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_val        <= n_val;
        r_res_data   <= n_res_data;
        r_res_status <= n_res_status;
    end

    // next state, memory access and compare unit
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_val        = r_val;
        n_res_data   = r_res_data;
        n_res_status = r_res_status;
        o_mem_we     = 1'b0;
        o_mem_waddr  = r_count[IW-1:0];
        o_mem_wdata  = r_val;
        o_mem_raddr  = r_idx[IW-1:0];
        o_req_ready  = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    if (i_kind == KIND_PUSH) begin
                        n_val      = i_value;
                        n_res_data = i_value;
                        if (r_count == '0) begin
                            // nothing to scan, an empty stack is never full
                            o_mem_we     = 1'b1;
                            o_mem_wdata  = i_value;
                            n_count      = w_count_inc;
                            n_res_status = ST_PUSHED;
                            n_state      = S_DONE;
                        end else begin
                            o_mem_raddr = '0;
                            n_idx       = AW'(1);
                            n_state     = S_SCAN;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res_data   = DATA_EMPTY;
                            n_res_status = ST_EMPTY;
                            n_state      = S_DONE;
                        end else begin
                            o_mem_raddr = w_count_dec[IW-1:0];
                            n_count     = w_count_dec;
                            n_state     = S_POP_RD;
                        end
                    end
                end
            end
            S_SCAN: begin
                // read data holds entry r_idx - 1
                if (i_mem_rdata == r_val) begin
                    n_res_status = ST_DUP;
                    n_state      = S_DONE;
                end else if (r_idx == r_count) begin
                    if (r_count == COUNT_FULL) begin
                        n_res_status = ST_FULL;
                    end else begin
                        o_mem_we     = 1'b1;
                        n_count      = w_count_inc;
                        n_res_status = ST_PUSHED;
                    end
                    n_state = S_DONE;
                end else begin
                    o_mem_raddr = r_idx[IW-1:0];
                    n_idx       = r_idx + AW'(1);
                end
            end
            S_POP_RD: begin
                n_res_data   = i_mem_rdata;
                n_res_status = ST_POPPED;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res.valid  = (r_state == S_DONE);
    assign o_res.data   = r_res_data;
    assign o_res.status = r_res_status;

endmodule

// ===== design/dedup_stack_core.sv =====
// ----------------------------------------------------------------------------
// dedup_stack_core - LIFO stack of signed words that refuses duplicates
// a push scans the stored entries one per cycle before it is placed
// ----------------------------------------------------------------------------
// push: one compare a cycle through the single read port of the entry store,
//   no scan when empty; the result then goes to the output register
// pop: reads the top entry; one request in flight, next accepted once the
//   result has moved to the output register
// synchronous active-low reset clears the fill count and the sequencer;
//   the entry store is not cleared
module dedup_stack_core #(
    parameter int unsigned DEPTH = 512
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ds_req_if.sink       i_req,
    ds_rsp_if.source     o_rsp
);
    import ds_pkg::*;

    localparam int unsigned IW = $clog2(DEPTH);

    logic                     w_mem_we;
    logic [IW-1:0]            w_mem_waddr;
    logic signed [DATA_W-1:0] w_mem_wdata;
    logic [IW-1:0]            w_mem_raddr;
    logic signed [DATA_W-1:0] w_mem_rdata;
    t_res                     w_res;
    logic                     w_take;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_data;
    t_status                  r_out_status;

    ds_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_kind      (i_req.kind),
        .i_value     (i_req.value),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata),
        .o_res       (w_res),
        .i_res_take  (w_take)
    );

    ds_ram #(.DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // output register takes the result when empty or being drained
    assign w_take = w_res.valid && (!r_out_valid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_data   <= w_res.data;
            r_out_status <= w_res.status;
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.data   = r_out_data;
    assign o_rsp.status = r_out_status;

endmodule

// ===== design/dedup_stack_chk.sv =====
// ----------------------------------------------------------------------------
// dedup_stack_chk - port-level checks of the dedup stack
// watches the request and response channels of the top level
// ----------------------------------------------------------------------------
module dedup_stack_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_req_ready,
    input  logic               i_rsp_valid,
    input  logic               i_rsp_ready,
    input  logic signed [31:0] i_rsp_data,
    input  logic [2:0]         i_rsp_status
);
    import ds_pkg::*;

    // a stalled response keeps its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_data) && $stable(i_rsp_status)))
        else $error("response payload changed while stalled");

    // one request at a time: busy right after a request is taken
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while previous one still in work");

    // an empty pop always returns all ones
    a_empty_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status == ST_EMPTY) |-> (i_rsp_data == DATA_EMPTY))
        else $error("empty status with data other than minus one");

    // reset drops the response channel
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

endmodule

bind dedup_stack_core dedup_stack_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_data   (o_rsp.data),
    .i_rsp_status (o_rsp.status)
);
